/* rtl/sqltok_pkg.sv */
// sqltok_pkg: types, codes, keyword table and helpers for the sql character tokenizer
// used by sqltok_step, sql_char_tokenizer and sqltok_checker; no dependencies
`timescale 1ns / 1ps

package sqltok_pkg;

  localparam int KEYWORD_CHARS_DEF = 10;
  localparam int LINE_WIDTH        = 16;
  localparam int COLUMN_WIDTH      = 16;
  localparam int LENGTH_WIDTH      = 16;
  localparam int NUM_KEYWORDS      = 69;

  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = '1;
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0, M_WORD = 4'd1, M_INT = 4'd2, M_FRAC = 4'd3, M_EXPS = 4'd4,
    M_EXPD = 4'd5, M_STR = 4'd6, M_ESC = 4'd7, M_OP = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    K_IDENT = 3'd0, K_KEYWORD = 3'd1, K_NUMBER = 3'd2, K_STRING = 3'd3,
    K_OPER = 3'd4, K_END = 3'd5, K_ERROR = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    OP_PLUS = 4'd0, OP_MINUS = 4'd1, OP_TIMES = 4'd2, OP_DIVIDE = 4'd3,
    OP_MOD = 4'd4, OP_EQUAL = 4'd5, OP_NOT_EQUAL = 4'd6, OP_LESS = 4'd7,
    OP_LESS_EQ = 4'd8, OP_GREATER = 4'd9, OP_GREATER_EQ = 4'd10, OP_DOT = 4'd11,
    OP_COMMA = 4'd12, OP_SEMICOLON = 4'd13, OP_LPAREN = 4'd14, OP_RPAREN = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ERR_UNEXPECTED = 2'd0, ERR_BANG = 2'd1, ERR_UNTERMINATED = 2'd2
  } err_t;

  // input transaction
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [2:0]              token_kind;
    logic [6:0]              keyword_index;
    logic [3:0]              operator_code;
    logic [1:0]              error_code;
    logic [LINE_WIDTH-1:0]   first_line;
    logic [COLUMN_WIDTH-1:0] first_column;
    logic [LENGTH_WIDTH-1:0] source_length;
    logic [LENGTH_WIDTH-1:0] value_length;
    logic                    last_result;
  } out_t;

  // scanner state except the word store
  typedef struct packed {
    mode_t                   mode;
    logic [7:0]              quote;
    logic                    too_long;
    logic [7:0]              pend;
    logic [LINE_WIDTH-1:0]   sline;
    logic [COLUMN_WIDTH-1:0] scol;
    logic [LINE_WIDTH-1:0]   line;
    logic [COLUMN_WIDTH-1:0] col;
    logic [LENGTH_WIDTH-1:0] scount;
    logic [LENGTH_WIDTH-1:0] vcount;
  } scan_t;

  // keyword text, right aligned, and lengths
  localparam logic [79:0] KW_TEXT [NUM_KEYWORDS] = '{
    80'("SELECT"), 80'("INSERT"), 80'("UPDATE"), 80'("DELETE"), 80'("CREATE"),
    80'("DROP"), 80'("ALTER"), 80'("TABLE"), 80'("INDEX"), 80'("FROM"),
    80'("WHERE"), 80'("GROUP"), 80'("BY"), 80'("ORDER"), 80'("HAVING"),
    80'("LIMIT"), 80'("OFFSET"), 80'("JOIN"), 80'("LEFT"), 80'("RIGHT"),
    80'("INNER"), 80'("OUTER"), 80'("ON"), 80'("AS"), 80'("AND"), 80'("OR"),
    80'("NOT"), 80'("IN"), 80'("EXISTS"), 80'("BETWEEN"), 80'("LIKE"),
    80'("IS"), 80'("NULL"), 80'("DISTINCT"), 80'("COUNT"), 80'("SUM"),
    80'("AVG"), 80'("MAX"), 80'("MIN"), 80'("PRIMARY"), 80'("KEY"),
    80'("FOREIGN"), 80'("REFERENCES"), 80'("UNIQUE"), 80'("CHECK"),
    80'("DEFAULT"), 80'("CONSTRAINT"), 80'("CASCADE"), 80'("RESTRICT"),
    80'("SET"), 80'("INT"), 80'("INTEGER"), 80'("BIGINT"), 80'("SMALLINT"),
    80'("TINYINT"), 80'("FLOAT"), 80'("DOUBLE"), 80'("DECIMAL"), 80'("NUMERIC"),
    80'("CHAR"), 80'("VARCHAR"), 80'("TEXT"), 80'("BLOB"), 80'("DATE"),
    80'("TIME"), 80'("DATETIME"), 80'("TIMESTAMP"), 80'("BOOLEAN"), 80'("BOOL")
  };

  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd5, 4'd4,
    4'd5, 4'd5, 4'd2, 4'd5, 4'd6, 4'd5, 4'd6, 4'd4, 4'd4, 4'd5,
    4'd5, 4'd5, 4'd2, 4'd2, 4'd3, 4'd2, 4'd3, 4'd2, 4'd6, 4'd7,
    4'd4, 4'd2, 4'd4, 4'd8, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7,
    4'd3, 4'd7, 4'd10, 4'd6, 4'd5, 4'd7, 4'd10, 4'd7, 4'd8, 4'd3,
    4'd3, 4'd7, 4'd6, 4'd8, 4'd7, 4'd5, 4'd6, 4'd7, 4'd7, 4'd4,
    4'd7, 4'd4, 4'd4, 4'd4, 4'd4, 4'd8, 4'd9, 4'd7, 4'd4
  };

  function automatic logic [LINE_WIDTH-1:0] sat_line(input logic [LINE_WIDTH-1:0] v);
    return (v == LINE_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [COLUMN_WIDTH-1:0] sat_col(input logic [COLUMN_WIDTH-1:0] v);
    return (v == COL_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_WIDTH-1:0] sat_len(input logic [LENGTH_WIDTH-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* rtl/sqltok_step.sv */
// sqltok_step: next scanner state and up to two results for one input byte
// depends on sqltok_pkg
`timescale 1ns / 1ps

module sqltok_step import sqltok_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  localparam int IW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1
) (
  input  scan_t                           st,
  input  logic [KEYWORD_CHARS-1:0][7:0]   word,
  input  in_t                             item,
  output scan_t                           st_next,
  output logic                            word_we,
  output logic [IW-1:0]                   word_idx,
  output logic [7:0]                      word_data,
  output out_t                            res0,
  output out_t                            res1,
  output logic [1:0]                      res_count
);

  logic [6:0] kw_idx;
  logic       kw_hit;

  function automatic out_t mk(input kind_t k, input logic [6:0] kw, input logic [3:0] op,
                              input logic [1:0] er, input logic [LINE_WIDTH-1:0] l,
                              input logic [COLUMN_WIDTH-1:0] c,
                              input logic [LENGTH_WIDTH-1:0] sl,
                              input logic [LENGTH_WIDTH-1:0] vl);
    out_t r;
    r.token_kind    = k;
    r.keyword_index = kw;
    r.operator_code = op;
    r.error_code    = er;
    r.first_line    = l;
    r.first_column  = c;
    r.source_length = sl;
    r.value_length  = vl;
    r.last_result   = 1'b0;
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // parallel keyword compare against the stored word
  always_comb begin
    logic m;
    kw_idx = '0;
    kw_hit = 1'b0;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      m = !st.too_long && (st.scount == LENGTH_WIDTH'(KW_LEN[i]));
      for (int j = 0; j < 10; j++) begin
        if (j < KW_LEN[i] && word[j] != KW_TEXT[i][(KW_LEN[i] - 1 - j) * 8 +: 8]) m = 1'b0;
      end
      if (m) begin
        kw_idx = 7'(i + 1);
        kw_hit = 1'b1;
      end
    end
  end

  // scanner step
  always_comb begin
    scan_t      s;
    out_t       r [2];
    out_t       x;
    logic [1:0] n;
    logic       do_start;
    logic       one_char;
    logic [7:0] c;
    logic [3:0] code;
    s         = st;
    r[0]      = '0;
    r[1]      = '0;
    x         = '0;
    n         = 2'd0;
    do_start  = 1'b0;
    one_char  = 1'b0;
    c         = item.text_byte;
    code      = OP_EQUAL;
    word_we   = 1'b0;
    word_idx  = '0;
    word_data = (c >= "a" && c <= "z") ? c - 8'd32 : c;

    if (item.end_of_text) begin
      // flush pending token then end of text
      unique case (st.mode)
        M_WORD: begin
          r[0] = mk(kw_hit ? K_KEYWORD : K_IDENT, kw_idx, '0, '0, st.sline, st.scol,
                    st.scount, st.scount);
          n = 2'd1;
        end
        M_INT, M_FRAC, M_EXPS, M_EXPD: begin
          r[0] = mk(K_NUMBER, '0, '0, '0, st.sline, st.scol, st.scount, st.scount);
          n = 2'd1;
        end
        M_STR, M_ESC: begin
          r[0] = mk(K_ERROR, '0, '0, ERR_UNTERMINATED, st.line, st.col, st.scount,
                    st.scount);
          n = 2'd1;
        end
        M_OP: begin
          if (st.pend == "!") r[0] = mk(K_ERROR, '0, '0, ERR_BANG, st.line, st.col,
                                        LENGTH_WIDTH'(1), LENGTH_WIDTH'(1));
          else r[0] = mk(K_OPER, '0, (st.pend == "<") ? OP_LESS :
                         (st.pend == ">") ? OP_GREATER : OP_EQUAL, '0, st.sline, st.scol,
                         LENGTH_WIDTH'(1), LENGTH_WIDTH'(1));
          n = 2'd1;
        end
        default: ;
      endcase
      r[n[0]] = mk(K_END, '0, '0, '0, st.line, st.col, '0, '0);
      n = n + 2'd1;
      s.mode     = M_IDLE;
      s.quote    = '0;
      s.too_long = 1'b0;
      s.pend     = '0;
      s.sline    = LINE_WIDTH'(1);
      s.scol     = COLUMN_WIDTH'(1);
      s.line     = LINE_WIDTH'(1);
      s.col      = COLUMN_WIDTH'(1);
      s.scount   = '0;
      s.vcount   = '0;
    end else begin
      unique case (st.mode)
        M_WORD: begin
          if (is_letter(c) || is_dig(c)) begin
            if (st.scount < LENGTH_WIDTH'(KEYWORD_CHARS)) begin
              word_we  = 1'b1;
              word_idx = st.scount[IW-1:0];
            end else begin
              s.too_long = 1'b1;
            end
            s.scount = sat_len(st.scount);
            s.col    = sat_col(st.col);
          end else begin
            r[0] = mk(kw_hit ? K_KEYWORD : K_IDENT, kw_idx, '0, '0, st.sline, st.scol,
                      st.scount, st.scount);
            n = 2'd1;
            do_start = 1'b1;
          end
        end
        M_INT, M_FRAC, M_EXPS, M_EXPD: begin
          if (is_dig(c) && st.mode != M_EXPS) begin
            s.mode = st.mode;
          end else if (st.mode == M_INT && c == ".") begin
            s.mode = M_FRAC;
          end else if ((st.mode == M_INT || st.mode == M_FRAC) && (c == "e" || c == "E")) begin
            s.mode = M_EXPS;
          end else if (st.mode == M_EXPS && (is_dig(c) || c == "+" || c == "-")) begin
            s.mode = M_EXPD;
          end else begin
            r[0] = mk(K_NUMBER, '0, '0, '0, st.sline, st.scol, st.scount, st.scount);
            n = 2'd1;
            do_start = 1'b1;
          end
          if (!do_start) begin
            s.scount = sat_len(st.scount);
            if (c == 8'h0a) begin
              s.line = sat_line(st.line);
              s.col  = COLUMN_WIDTH'(1);
            end else begin
              s.col = sat_col(st.col);
            end
          end
        end
        M_STR, M_ESC: begin
          s.scount = sat_len(st.scount);
          if (c == 8'h0a) begin
            s.line = sat_line(st.line);
            s.col  = COLUMN_WIDTH'(1);
          end else begin
            s.col = sat_col(st.col);
          end
          if (st.mode == M_ESC) begin
            s.vcount = sat_len(st.vcount);
            s.mode   = M_STR;
          end else if (c == st.quote) begin
            r[0] = mk(K_STRING, '0, '0, '0, st.sline, st.scol, s.scount, st.vcount);
            n = 2'd1;
            s.mode = M_IDLE;
          end else if (c == "\\") begin
            s.mode = M_ESC;
          end else begin
            s.vcount = sat_len(st.vcount);
          end
        end
        M_OP: begin
          if (c == "=") begin
            s.col = sat_col(st.col);
            unique case (st.pend)
              "!":     code = OP_NOT_EQUAL;
              "<":     code = OP_LESS_EQ;
              ">":     code = OP_GREATER_EQ;
              default: code = OP_EQUAL;
            endcase
            r[0] = mk(K_OPER, '0, code, '0, st.sline, st.scol, LENGTH_WIDTH'(2),
                      LENGTH_WIDTH'(2));
            n = 2'd1;
            s.mode = M_IDLE;
          end else begin
            if (st.pend == "!") r[0] = mk(K_ERROR, '0, '0, ERR_BANG, st.line, st.col,
                                          LENGTH_WIDTH'(1), LENGTH_WIDTH'(1));
            else r[0] = mk(K_OPER, '0, (st.pend == "<") ? OP_LESS :
                           (st.pend == ">") ? OP_GREATER : OP_EQUAL, '0, st.sline, st.scol,
                           LENGTH_WIDTH'(1), LENGTH_WIDTH'(1));
            n = 2'd1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      // byte that begins a new token
      if (do_start) begin
        s.mode = M_IDLE;
        if (c == 8'h0a) begin
          s.line = sat_line(st.line);
          s.col  = COLUMN_WIDTH'(1);
        end else begin
          s.col = sat_col(st.col);
        end
        if (!is_space(c)) begin
          s.sline = st.line;
          s.scol  = st.col;
          if (is_letter(c)) begin
            s.mode     = M_WORD;
            s.too_long = 1'b0;
            s.scount   = LENGTH_WIDTH'(1);
            word_we    = 1'b1;
            word_idx   = '0;
          end else if (is_dig(c)) begin
            s.mode   = M_INT;
            s.scount = LENGTH_WIDTH'(1);
          end else if (c == "'" || c == "\"") begin
            s.mode   = M_STR;
            s.quote  = c;
            s.scount = LENGTH_WIDTH'(1);
            s.vcount = '0;
          end else if (c == "=" || c == "<" || c == ">" || c == "!") begin
            s.mode = M_OP;
            s.pend = c;
          end else begin
            // single-character operator or stray byte
            one_char = 1'b1;
            unique case (c)
              "+":     code = OP_PLUS;
              "-":     code = OP_MINUS;
              "*":     code = OP_TIMES;
              "/":     code = OP_DIVIDE;
              "%":     code = OP_MOD;
              ".":     code = OP_DOT;
              ",":     code = OP_COMMA;
              ";":     code = OP_SEMICOLON;
              "(":     code = OP_LPAREN;
              ")":     code = OP_RPAREN;
              default: one_char = 1'b0;
            endcase
            if (one_char) x = mk(K_OPER, '0, code, '0, st.line, st.col, LENGTH_WIDTH'(1),
                                 LENGTH_WIDTH'(1));
            else x = mk(K_ERROR, '0, '0, ERR_UNEXPECTED, s.line, s.col, LENGTH_WIDTH'(1),
                        LENGTH_WIDTH'(1));
            r[n[0]] = x;
            n = n + 2'd1;
          end
        end
      end
    end

    if (n == 2'd1) r[0].last_result = 1'b1;
    if (n == 2'd2) r[1].last_result = 1'b1;
    st_next   = s;
    res0      = r[0];
    res1      = r[1];
    res_count = n;
  end

endmodule

/* rtl/sql_char_tokenizer.sv */
// Takes one text byte (or the end marker) per cycle when text_stall is low; each byte is
// scanned in the cycle it is accepted and gives zero, one or two tokens, which go into a
// four-entry result queue drained at one token per cycle when token_stall is low.
// text_stall rises while fewer than two queue entries are free, so the sustained rate is
// one byte per cycle if the token side keeps up; a byte can close a token and open another.
// sql_char_tokenizer: top level, scanner state registers and result queue
// depends on sqltok_pkg and sqltok_step
`timescale 1ns / 1ps

module sql_char_tokenizer import sqltok_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic text_valid,
  output logic text_stall,
  input  in_t  text,
  output logic token_valid,
  input  logic token_stall,
  output out_t token
);

  localparam int IW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

  scan_t                         st, st_next;
  logic [KEYWORD_CHARS-1:0][7:0] word;
  logic                          word_we;
  logic [IW-1:0]                 word_idx;
  logic [7:0]                    word_data;
  out_t                          res0, res1;
  logic [1:0]                    res_count;
  out_t                          queue [4];
  logic [1:0]                    wr_ptr, rd_ptr;
  logic [2:0]                    fill;
  logic                          take, pop;

  sqltok_step #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_step (
    .st        (st),
    .word      (word),
    .item      (text),
    .st_next   (st_next),
    .word_we   (word_we),
    .word_idx  (word_idx),
    .word_data (word_data),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  assign text_stall  = fill > 3'd2;
  assign take        = text_valid && !text_stall;
  assign token_valid = fill != 3'd0;
  assign token       = queue[rd_ptr];
  assign pop         = token_valid && !token_stall;

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode     <= M_IDLE;
      st.quote    <= '0;
      st.too_long <= 1'b0;
      st.pend     <= '0;
      st.sline    <= LINE_WIDTH'(1);
      st.scol     <= COLUMN_WIDTH'(1);
      st.line     <= LINE_WIDTH'(1);
      st.col      <= COLUMN_WIDTH'(1);
      st.scount   <= '0;
      st.vcount   <= '0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // word store
  always_ff @(posedge clk) begin
    if (take && word_we) word[word_idx] <= word_data;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (take && res_count != 2'd0) queue[wr_ptr] <= res0;
      if (take && res_count == 2'd2) queue[wr_ptr + 2'd1] <= res1;
      if (take) wr_ptr <= wr_ptr + res_count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + (take ? {1'b0, res_count} : 3'd0) - {2'b0, pop};
    end
  end

endmodule

/* rtl/sqltok_checker.sv */
// sqltok_checker: port-level assertions for sql_char_tokenizer, bound to the top level
// depends on sqltok_pkg
`timescale 1ns / 1ps

module sqltok_checker import sqltok_pkg::*; (
  input logic clk,
  input logic rst,
  input logic text_valid,
  input logic text_stall,
  input in_t  text,
  input logic token_valid,
  input logic token_stall,
  input out_t token
);

  // a stalled token transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token))
    else $error("token changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !token_valid)
    else $error("token valid after reset");

  // end of text is always the last token of its byte and empty
  a_end: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind == K_END |->
      token.last_result && token.source_length == '0)
    else $error("bad end-of-text token");

  // only strings have a value length apart from the source length
  a_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind != K_STRING |->
      token.value_length == token.source_length)
    else $error("length mismatch on non-string token");

  // an accepted end marker always leaves a token waiting
  a_eot: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_stall && text.end_of_text |=> token_valid)
    else $error("no token after end of text");

endmodule

bind sql_char_tokenizer sqltok_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .text_valid  (text_valid),
  .text_stall  (text_stall),
  .text        (text),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token       (token)
);

/* tb/tb_top.sv */
// tb_top: self-checking testbench for the sql character tokenizer, with a directed table,
// random token streams and random idling on both sides
// depends on sqltok_pkg and sql_char_tokenizer
`timescale 1ns / 1ps

module tb_top;
  import sqltok_pkg::*;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_stall;
  in_t  text = '0;
  logic token_valid;
  logic token_stall = 1'b0;
  out_t token;

  out_t     expected_tokens[$];
  in_t      text_stream[$];
  dir_row_t directed_rows[$];
  int       failed = 0;
  bit       sender_gaps = 1'b1;
  bit       receiver_gaps = 1'b1;
  bit       hold_request = 1'b0;

  // scanner image
  mode_t                   scan_mode;
  logic [7:0]              quote_ch;
  logic [7:0]              word_buf [10];
  bit                      word_long;
  logic [7:0]              pend_ch;
  logic [LINE_WIDTH-1:0]   tok_line, cur_line;
  logic [COLUMN_WIDTH-1:0] tok_col, cur_col;
  logic [LENGTH_WIDTH-1:0] src_count, val_count;
  out_t                    step_tokens [2];
  int                      step_count;

  sql_char_tokenizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic out_t mk_token(input kind_t k, input int kw, input int op, input int err,
                                    input int ln, input int cl, input int sl, input int vl,
                                    input bit last);
    out_t t;
    t.token_kind    = k;
    t.keyword_index = kw[6:0];
    t.operator_code = op[3:0];
    t.error_code    = err[1:0];
    t.first_line    = ln[15:0];
    t.first_column  = cl[15:0];
    t.source_length = sl[15:0];
    t.value_length  = vl[15:0];
    t.last_result   = last;
    return t;
  endfunction

  function automatic bit letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit single_op(input logic [7:0] c, output op_t code);
    single_op = 1'b1;
    case (c)
      "+": code = OP_PLUS;
      "-": code = OP_MINUS;
      "*": code = OP_TIMES;
      "/": code = OP_DIVIDE;
      "%": code = OP_MOD;
      "=": code = OP_EQUAL;
      "<": code = OP_LESS;
      ">": code = OP_GREATER;
      ".": code = OP_DOT;
      ",": code = OP_COMMA;
      ";": code = OP_SEMICOLON;
      "(": code = OP_LPAREN;
      ")": code = OP_RPAREN;
      default: begin
        code = OP_PLUS;
        single_op = 1'b0;
      end
    endcase
  endfunction

  function void clear_scanner();
    scan_mode = M_IDLE;
    quote_ch  = '0;
    word_long = 1'b0;
    pend_ch   = '0;
    tok_line  = 1;
    tok_col   = 1;
    cur_line  = 1;
    cur_col   = 1;
    src_count = '0;
    val_count = '0;
    foreach (word_buf[i]) word_buf[i] = '0;
  endfunction

  function void add_token(input kind_t k, input int kw, input int op, input int err,
                          input logic [15:0] ln, input logic [15:0] cl,
                          input logic [15:0] sl, input logic [15:0] vl);
    if (step_count < 2) begin
      step_tokens[step_count] = mk_token(k, kw, op, err, ln, cl, sl, vl, 1'b0);
      step_count++;
    end
  endfunction

  function void move_pos(input logic [7:0] c);
    if (c == 8'h0A) begin
      cur_line = bump(cur_line);
      cur_col  = 1;
    end else begin
      cur_col = bump(cur_col);
    end
  endfunction

  function void word_push(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (src_count < 10) word_buf[src_count] = u;
    else word_long = 1'b1;
    src_count = bump(src_count);
  endfunction

  // keyword lookup against the right-aligned package table
  function void close_word();
    logic [79:0] w;
    int kw;
    w  = '0;
    kw = 0;
    if (!word_long) begin
      for (int i = 0; i < 10; i++) if (i < src_count) w = {w[71:0], word_buf[i]};
      for (int k = 0; k < NUM_KEYWORDS; k++)
        if (kw == 0 && KW_LEN[k] == src_count && KW_TEXT[k] == w) kw = k + 1;
    end
    add_token(kw != 0 ? K_KEYWORD : K_IDENT, kw, 0, 0, tok_line, tok_col,
              src_count, src_count);
  endfunction

  function void close_pending_op();
    op_t code;
    if (pend_ch == "!") begin
      add_token(K_ERROR, 0, 0, ERR_BANG, cur_line, cur_col, 1, 1);
    end else begin
      void'(single_op(pend_ch, code));
      add_token(K_OPER, 0, code, 0, tok_line, tok_col, 1, 1);
    end
  endfunction

  function void begin_token(input logic [7:0] c);
    op_t code;
    scan_mode = M_IDLE;
    if (is_blank(c)) begin
      move_pos(c);
      return;
    end
    tok_line = cur_line;
    tok_col  = cur_col;
    if (letter_char(c)) begin
      scan_mode = M_WORD;
      src_count = 0;
      word_long = 1'b0;
      word_push(c);
    end else if (digit_char(c)) begin
      scan_mode = M_INT;
      src_count = 1;
    end else if (c == "'" || c == "\"") begin
      scan_mode = M_STR;
      quote_ch  = c;
      src_count = 1;
      val_count = 0;
    end else if (c == "=" || c == "<" || c == ">" || c == "!") begin
      scan_mode = M_OP;
      pend_ch   = c;
    end else begin
      move_pos(c);
      if (single_op(c, code)) add_token(K_OPER, 0, code, 0, tok_line, tok_col, 1, 1);
      else add_token(K_ERROR, 0, 0, ERR_UNEXPECTED, cur_line, cur_col, 1, 1);
      return;
    end
    move_pos(c);
  endfunction

  // works out the tokens caused by one accepted transaction
  function void scan_item(input in_t it);
    logic [7:0] c;
    op_t code;
    c = it.text_byte;
    step_count = 0;
    if (it.end_of_text) begin
      case (scan_mode)
        M_WORD: close_word();
        M_INT, M_FRAC, M_EXPS, M_EXPD:
          add_token(K_NUMBER, 0, 0, 0, tok_line, tok_col, src_count, src_count);
        M_STR, M_ESC:
          add_token(K_ERROR, 0, 0, ERR_UNTERMINATED, cur_line, cur_col, src_count, src_count);
        M_OP: close_pending_op();
        default: ;
      endcase
      add_token(K_END, 0, 0, 0, cur_line, cur_col, 0, 0);
      clear_scanner();
    end else begin
      case (scan_mode)
        M_WORD: begin
          if (letter_char(c) || digit_char(c)) begin
            word_push(c);
            move_pos(c);
          end else begin
            close_word();
            begin_token(c);
          end
        end
        M_INT, M_FRAC, M_EXPS, M_EXPD: begin
          if (digit_char(c) && scan_mode != M_EXPS) begin
            src_count = bump(src_count);
            move_pos(c);
          end else if (scan_mode == M_INT && c == ".") begin
            scan_mode = M_FRAC;
            src_count = bump(src_count);
            move_pos(c);
          end else if ((scan_mode == M_INT || scan_mode == M_FRAC) && (c == "e" || c == "E")) begin
            scan_mode = M_EXPS;
            src_count = bump(src_count);
            move_pos(c);
          end else if (scan_mode == M_EXPS && (digit_char(c) || c == "+" || c == "-")) begin
            scan_mode = M_EXPD;
            src_count = bump(src_count);
            move_pos(c);
          end else begin
            add_token(K_NUMBER, 0, 0, 0, tok_line, tok_col, src_count, src_count);
            begin_token(c);
          end
        end
        M_STR: begin
          src_count = bump(src_count);
          move_pos(c);
          if (c == quote_ch) begin
            add_token(K_STRING, 0, 0, 0, tok_line, tok_col, src_count, val_count);
            scan_mode = M_IDLE;
          end else if (c == "\\") begin
            scan_mode = M_ESC;
          end else begin
            val_count = bump(val_count);
          end
        end
        M_ESC: begin
          src_count = bump(src_count);
          val_count = bump(val_count);
          move_pos(c);
          scan_mode = M_STR;
        end
        M_OP: begin
          if (c == "=") begin
            move_pos(c);
            case (pend_ch)
              "!":     code = OP_NOT_EQUAL;
              "<":     code = OP_LESS_EQ;
              ">":     code = OP_GREATER_EQ;
              default: code = OP_EQUAL;
            endcase
            add_token(K_OPER, 0, code, 0, tok_line, tok_col, 2, 2);
            scan_mode = M_IDLE;
          end else begin
            close_pending_op();
            begin_token(c);
          end
        end
        default: begin_token(c);
      endcase
    end
    if (step_count > 0) step_tokens[step_count-1].last_result = 1'b1;
  endfunction

  // stream builders
  function void put_byte(input logic [7:0] b);
    in_t it;
    it.text_byte   = b;
    it.end_of_text = 1'b0;
    text_stream.insert(text_stream.size(), it);
  endfunction

  function void put_end();
    in_t it;
    it.text_byte   = $urandom_range(0, 255);
    it.end_of_text = 1'b1;
    text_stream.insert(text_stream.size(), it);
  endfunction

  function logic [7:0] pick_alnum();
    case ($urandom_range(0, 3))
      0:       return "a" + $urandom_range(0, 25);
      1:       return "A" + $urandom_range(0, 25);
      2:       return "0" + $urandom_range(0, 9);
      default: return "_";
    endcase
  endfunction

  function void put_spaces();
    logic [7:0] ws [6] = '{" ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    repeat ($urandom_range(1, 2)) put_byte(ws[$urandom_range(0, 5)]);
  endfunction

  // one random token, well formed most of the time
  function void put_random_token();
    logic [7:0] ops [14] = '{"+", "-", "*", "/", "%", "=", "<", ">", "!", ".", ",", ";",
                             "(", ")"};
    logic [7:0] c, q;
    int k, n;
    case ($urandom_range(0, 9))
      0, 1: begin
        k = $urandom_range(0, NUM_KEYWORDS - 1);
        for (int i = KW_LEN[k] - 1; i >= 0; i--) begin
          c = KW_TEXT[k][8*i +: 8];
          if ($urandom_range(0, 1)) c = c | 8'h20;
          put_byte(c);
        end
      end
      2: begin
        c = $urandom_range(0, 1) ? "_" : "a" + $urandom_range(0, 25);
        put_byte(c);
        n = $urandom_range(0, 12);
        repeat (n) put_byte(pick_alnum());
      end
      3: begin
        repeat ($urandom_range(1, 4)) put_byte("0" + $urandom_range(0, 9));
        if ($urandom_range(0, 1)) begin
          put_byte(".");
          repeat ($urandom_range(0, 3)) put_byte("0" + $urandom_range(0, 9));
        end
        if ($urandom_range(0, 1)) begin
          put_byte($urandom_range(0, 1) ? "e" : "E");
          n = $urandom_range(0, 2);
          if (n == 1) put_byte("+");
          if (n == 2) put_byte("-");
          repeat ($urandom_range(0, 3)) put_byte("0" + $urandom_range(0, 9));
        end
      end
      4, 5: begin
        q = $urandom_range(0, 1) ? "'" : "\"";
        put_byte(q);
        repeat ($urandom_range(0, 10)) begin
          case ($urandom_range(0, 7))
            0: begin
              put_byte("\\");
              put_byte($urandom_range(0, 3) == 0 ? q : $urandom_range(32, 126));
            end
            1:       put_byte(8'h0A);
            2:       put_byte(q == "'" ? "\"" : "'");
            default: begin
              c = $urandom_range(0, 255);
              if (c == q || c == "\\") c = "z";
              put_byte(c);
            end
          endcase
        end
        if ($urandom_range(0, 9) != 0) put_byte(q);
      end
      6, 7: begin
        put_byte(ops[$urandom_range(0, 13)]);
        if ($urandom_range(0, 2) == 0) put_byte("=");
      end
      8:       put_byte($urandom_range(0, 255));
      default: put_end();
    endcase
    if ($urandom_range(0, 3) != 0) put_spaces();
  endfunction

  function void add_row(input logic [7:0] b, input bit eot, input bit typed, input out_t want);
    dir_row_t r;
    r.item.text_byte   = b;
    r.item.end_of_text = eot;
    r.typed            = typed;
    r.want             = want;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // offers one transaction and records its tokens once accepted
  task automatic send_item(input in_t it, input bit typed, input out_t want);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text       <= it;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    scan_item(it);
    if (typed) expected_tokens.insert(expected_tokens.size(), want);
    else for (int i = 0; i < step_count; i++)
      expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endtask

  task automatic send_stream();
    out_t none;
    none = '0;
    while (text_stream.size() > 0) begin
      if ($urandom_range(0, 59) == 0) sender_gaps = ~sender_gaps;
      send_item(text_stream.pop_front(), 1'b0, none);
    end
  endtask

  // token side stalls
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 49) == 0) receiver_gaps = ~receiver_gaps;
      if (hold_request) begin
        n = 300;
        hold_request = 1'b0;
      end else begin
        n = receiver_gaps ? $urandom_range(0, 18) : 0;
      end
      if (n > 0) begin
        token_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      token_stall <= 1'b0;
      @(posedge clk);
      while (!token_valid) @(posedge clk);
    end
  end

  function void cmp_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      failed++;
    end
  endfunction

  // compare each accepted token with the oldest expectation
  always @(posedge clk) begin
    out_t e;
    if (!rst && token_valid && !token_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("token_kind: expected none, got %0d", token.token_kind);
        failed++;
      end else begin
        e = expected_tokens.pop_front();
        cmp_field("token_kind", e.token_kind, token.token_kind);
        cmp_field("keyword_index", e.keyword_index, token.keyword_index);
        cmp_field("operator_code", e.operator_code, token.operator_code);
        cmp_field("error_code", e.error_code, token.error_code);
        cmp_field("first_line", e.first_line, token.first_line);
        cmp_field("first_column", e.first_column, token.first_column);
        cmp_field("source_length", e.source_length, token.source_length);
        cmp_field("value_length", e.value_length, token.value_length);
        cmp_field("last_result", e.last_result, token.last_result);
      end
    end
  end

  initial begin
    #500000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    string dir_text;
    out_t none;
    none = '0;
    clear_scanner();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty text, bad bytes, operator pairs, lone bang, number, escaped string
    add_row(8'h00, 1'b1, 1'b1, mk_token(K_END, 0, 0, 0, 1, 1, 0, 0, 1'b1));
    add_row(8'h00, 1'b0, 1'b1, mk_token(K_ERROR, 0, 0, ERR_UNEXPECTED, 1, 2, 1, 1, 1'b1));
    add_row(8'hFF, 1'b0, 1'b1, mk_token(K_ERROR, 0, 0, ERR_UNEXPECTED, 1, 3, 1, 1, 1'b1));
    dir_text = "!!=<>=a1.5e-2'\\'x";
    for (int i = 0; i < dir_text.len(); i++) add_row(dir_text[i], 1'b0, 1'b0, none);
    add_row(8'h80, 1'b1, 1'b0, none);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    text_valid <= 1'b0;
    wait (expected_tokens.size() == 0);

    // hold the token side off while bytes keep coming, so the queue backs up
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    repeat (20) begin
      put_byte("+");
      put_byte("(");
    end
    send_stream();
    sender_gaps = 1'b1;

    // random token streams
    while (text_stream.size() < 650) put_random_token();
    put_end();
    send_stream();
    text_valid <= 1'b0;

    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (failed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
